### rtl/core/abr_pkg.sv
// Package for the alternating-bit receiver: result types, parse phase codes,
// ASCII constants and small helper functions. No dependencies.
package abr_pkg;

    localparam int RES_FIFO_DEPTH = 4;

    // parse phase codes
    localparam logic [2:0] PH_SEQ     = 3'd0;
    localparam logic [2:0] PH_CKLEN   = 3'd1;
    localparam logic [2:0] PH_CKVAL   = 3'd2;
    localparam logic [2:0] PH_LENLEN  = 3'd3;
    localparam logic [2:0] PH_LENVAL  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [5:0] ACK_ZERO   = 6'h30;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [5:0] ack_seq;
        logic       accepted;
        logic       malformed;
        logic       all_done;
        logic       run_end;
    } result_t;

    // up to two results written per accepted byte; second is always a verdict
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    // v * 10 + d, modulo 2^16
    function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [3:0] d);
        acc_digit = (v << 3) + (v << 1) + {12'd0, d};
    endfunction

    // 16-bit ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        oc_add = s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

### rtl/core/alternating_bit_receiver_top.sv
// Alternating-bit packet receiver, top level.
// Input: one packet byte per transaction on s_valid/s_ready, s_pkt_last on
// the final byte. Output: one result per transaction on m_valid/m_ready;
// m_kind 0 passes a payload byte, m_kind 1 is the end-of-packet verdict
// (ack character, accepted, malformed, all_done); m_run_end marks the last
// result caused by an input byte.
// Latency: a result shows on m the cycle after its byte is accepted if none
// is queued ahead of it. Throughput: one byte per cycle while s_ready is
// high; a payload byte with s_pkt_last yields two results.
// s_ready is high while the result queue has room for two results, so a
// stalled m side fills the queue and then holds the input side off.
// cfg_wr_en/cfg_wr_data write packets_expected; the user must do so only
// while idle, unchecked by the block. Reset (aresetn low, synchronous)
// empties the queue, expects sequence '0', clears the accepted count and
// packets_expected. Depends on abr_pkg, abr_rx_core, abr_res_fifo.
module alternating_bit_receiver_top #(
    parameter int RES_DEPTH = abr_pkg::RES_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pkt_byte,
    input  logic        s_pkt_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [5:0]  m_ack_seq,
    output logic        m_accepted,
    output logic        m_malformed,
    output logic        m_all_done,
    output logic        m_run_end,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import abr_pkg::*;

    logic [15:0] pkts_expected_reg;
    logic        in_fire;
    logic        room2;
    push_t       push;
    result_t     head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkts_expected_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            pkts_expected_reg <= cfg_wr_data;
        end
    end

    assign s_ready = room2;
    assign in_fire = s_valid && room2;

    abr_rx_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_fire          (in_fire),
        .pkt_byte         (s_pkt_byte),
        .pkt_last         (s_pkt_last),
        .packets_expected (pkts_expected_reg),
        .push             (push)
    );

    abr_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_valid && m_ready),
        .head      (head),
        .not_empty (m_valid),
        .has_room2 (room2)
    );

    assign m_kind         = head.kind;
    assign m_payload_byte = head.payload_byte;
    assign m_ack_seq      = head.ack_seq;
    assign m_accepted     = head.accepted;
    assign m_malformed    = head.malformed;
    assign m_all_done     = head.all_done;
    assign m_run_end      = head.run_end;

endmodule

### rtl/core/abr_res_fifo.sv
// Result queue: small register FIFO taking up to two results per cycle and
// presenting one per output transaction. Depends on abr_pkg.
module abr_res_fifo #(
    parameter int DEPTH = abr_pkg::RES_FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  abr_pkg::push_t  push,
    input  logic            pop,
    output abr_pkg::result_t head,
    output logic            not_empty,
    output logic            has_room2
);
    import abr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push.n == 2'd1) begin
            wr_ptr_next = wr_ptr_inc;
        end else if (push.n == 2'd2) begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign has_room2 = ({1'b0, count_reg} + (CNT_W + 1)'(2)) <= (CNT_W + 1)'(DEPTH);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count above depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_reg} + (CNT_W + 1)'(push.n)) <= (CNT_W + 1)'(DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("result queue popped while empty");

endmodule

### rtl/core/abr_rx_core.sv
// Packet parser, ones'-complement checksum and verdict logic; produces the
// results for each accepted byte. Depends on abr_pkg.
module abr_rx_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic [7:0]     pkt_byte,
    input  logic           pkt_last,
    input  logic [15:0]    packets_expected,
    output abr_pkg::push_t push
);
    import abr_pkg::*;

    logic        expected_seq_reg, expected_seq_next;
    logic [2:0]  phase_reg, phase_next;
    logic        seq_matched_reg, seq_matched_next;
    logic [3:0]  digits_left_reg, digits_left_next;
    logic        digits_stopped_reg, digits_stopped_next;
    logic [15:0] ck_value_reg, ck_value_next;
    logic [15:0] pay_len_reg, pay_len_next;
    logic [15:0] pay_left_reg, pay_left_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  held_reg, held_next;
    logic        have_held_reg, have_held_next;
    logic [15:0] acc_count_reg, acc_count_next;

    logic [3:0]  cnt_digit;
    logic [15:0] len_acc;
    logic [15:0] add_word, add_out;
    logic        pay_hit, mal, acc;
    logic [5:0]  ack;
    result_t     pay_res, verd_res;

    always_comb begin
        expected_seq_next   = expected_seq_reg;
        phase_next          = phase_reg;
        seq_matched_next    = seq_matched_reg;
        digits_left_next    = digits_left_reg;
        digits_stopped_next = digits_stopped_reg;
        ck_value_next       = ck_value_reg;
        pay_len_next        = pay_len_reg;
        pay_left_next       = pay_left_reg;
        sum_next            = sum_reg;
        held_next           = held_reg;
        have_held_next      = have_held_reg;
        acc_count_next      = acc_count_reg;
        pay_hit             = 1'b0;

        cnt_digit = is_digit(pkt_byte) ? pkt_byte[3:0] : 4'd0;
        len_acc   = pay_len_reg;
        if (!digits_stopped_reg && is_digit(pkt_byte)) begin
            len_acc = acc_digit(pay_len_reg, pkt_byte[3:0]);
        end

        // single adder: pairs a word into the sum, or adds the odd byte for the verdict
        if (phase_reg == PH_PAYLOAD) begin
            add_word = have_held_reg ? {pkt_byte, held_reg} : {8'd0, pkt_byte};
        end else begin
            add_word = have_held_reg ? {8'd0, held_reg} : 16'd0;
        end
        add_out = oc_add(sum_reg, add_word);

        if (in_fire) begin
            case (phase_reg)
                PH_SEQ: begin
                    seq_matched_next = (pkt_byte == (ASCII_ZERO | {7'd0, expected_seq_reg}));
                    phase_next       = PH_CKLEN;
                end
                PH_CKLEN: begin
                    digits_left_next    = cnt_digit;
                    digits_stopped_next = 1'b0;
                    ck_value_next       = 16'd0;
                    phase_next          = (cnt_digit == 4'd0) ? PH_LENLEN : PH_CKVAL;
                end
                PH_CKVAL: begin
                    if (!digits_stopped_reg) begin
                        if (is_digit(pkt_byte)) begin
                            ck_value_next = acc_digit(ck_value_reg, pkt_byte[3:0]);
                        end else begin
                            digits_stopped_next = 1'b1;
                        end
                    end
                    digits_left_next = digits_left_reg - 4'd1;
                    if (digits_left_reg == 4'd1) begin
                        phase_next = PH_LENLEN;
                    end
                end
                PH_LENLEN: begin
                    digits_left_next    = cnt_digit;
                    digits_stopped_next = 1'b0;
                    pay_len_next        = 16'd0;
                    if (cnt_digit == 4'd0) begin
                        pay_left_next = 16'd0;
                        phase_next    = PH_DONE;
                    end else begin
                        phase_next = PH_LENVAL;
                    end
                end
                PH_LENVAL: begin
                    pay_len_next = len_acc;
                    if (!digits_stopped_reg && !is_digit(pkt_byte)) begin
                        digits_stopped_next = 1'b1;
                    end
                    digits_left_next = digits_left_reg - 4'd1;
                    if (digits_left_reg == 4'd1) begin
                        pay_left_next = len_acc;
                        phase_next    = (len_acc == 16'd0) ? PH_DONE : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    pay_hit = 1'b1;
                    if (have_held_reg) begin
                        sum_next       = add_out;
                        have_held_next = 1'b0;
                    end else begin
                        held_next      = pkt_byte;
                        have_held_next = 1'b1;
                    end
                    pay_left_next = pay_left_reg - 16'd1;
                    if (pay_left_reg == 16'd1) begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        mal = (phase_next != PH_DONE);
        acc = seq_matched_next && !mal && (~add_out == ck_value_next);
        ack = ACK_ZERO | {5'd0, expected_seq_reg ^ !acc};

        if (in_fire && pkt_last) begin
            if (acc) begin
                expected_seq_next = !expected_seq_reg;
                if (acc_count_reg != COUNT_MAX) begin
                    acc_count_next = acc_count_reg + 16'd1;
                end
            end
            phase_next          = PH_SEQ;
            seq_matched_next    = 1'b0;
            digits_left_next    = 4'd0;
            digits_stopped_next = 1'b0;
            ck_value_next       = 16'd0;
            pay_len_next        = 16'd0;
            pay_left_next       = 16'd0;
            sum_next            = 16'd0;
            held_next           = 8'd0;
            have_held_next      = 1'b0;
        end

        pay_res.kind         = KIND_PAYLOAD;
        pay_res.payload_byte = pkt_byte;
        pay_res.ack_seq      = ACK_ZERO;
        pay_res.accepted     = 1'b0;
        pay_res.malformed    = 1'b0;
        pay_res.all_done     = (acc_count_reg >= packets_expected);
        pay_res.run_end      = !pkt_last;

        verd_res.kind         = KIND_VERDICT;
        verd_res.payload_byte = 8'd0;
        verd_res.ack_seq      = ack;
        verd_res.accepted     = acc;
        verd_res.malformed    = mal;
        verd_res.all_done     = (acc_count_next >= packets_expected);
        verd_res.run_end      = 1'b1;

        push.first  = pay_hit ? pay_res : verd_res;
        push.second = verd_res;
        if (!in_fire) begin
            push.n = 2'd0;
        end else begin
            push.n = {1'b0, pay_hit} + {1'b0, pkt_last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_seq_reg   <= 1'b0;
            phase_reg          <= PH_SEQ;
            seq_matched_reg    <= 1'b0;
            digits_left_reg    <= 4'd0;
            digits_stopped_reg <= 1'b0;
            ck_value_reg       <= 16'd0;
            pay_len_reg        <= 16'd0;
            pay_left_reg       <= 16'd0;
            sum_reg            <= 16'd0;
            held_reg           <= 8'd0;
            have_held_reg      <= 1'b0;
            acc_count_reg      <= 16'd0;
        end else begin
            expected_seq_reg   <= expected_seq_next;
            phase_reg          <= phase_next;
            seq_matched_reg    <= seq_matched_next;
            digits_left_reg    <= digits_left_next;
            digits_stopped_reg <= digits_stopped_next;
            ck_value_reg       <= ck_value_next;
            pay_len_reg        <= pay_len_next;
            pay_left_reg       <= pay_left_next;
            sum_reg            <= sum_next;
            held_reg           <= held_next;
            have_held_reg      <= have_held_next;
            acc_count_reg      <= acc_count_next;
        end
    end

    a_digits_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CKVAL || phase_reg == PH_LENVAL) |-> digits_left_reg != 4'd0)
        else $error("digit phase with no digits left");

    a_payload_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> pay_left_reg != 16'd0)
        else $error("payload phase with no bytes left");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && pkt_last) |=> (phase_reg == PH_SEQ && sum_reg == 16'd0 && !have_held_reg))
        else $error("packet state not cleared after last byte");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd2) |-> (push.first.kind == KIND_PAYLOAD && push.second.kind == KIND_VERDICT))
        else $error("result pair out of order");

endmodule

### tb/abr_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the alternating-bit receiver: tracks packet parsing per input
// transaction, predicts payload and verdict results, compares them on the result channel.
// Depends on abr_pkg; instantiated by tb_alternating_bit_receiver_top.
module abr_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_pkt_byte,
    input  logic        s_pkt_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [7:0]  m_payload_byte,
    input  logic [5:0]  m_ack_seq,
    input  logic        m_accepted,
    input  logic        m_malformed,
    input  logic        m_all_done,
    input  logic        m_run_end,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          mismatches,
    output int          pending,
    output logic        want_seq
);
    import abr_pkg::*;

    logic [15:0] target_count;
    logic [15:0] good_count;
    logic [2:0]  phase;
    logic        seq_ok;
    logic [3:0]  digits;
    logic        stopped;
    logic [15:0] hdr_sum;
    logic [15:0] pay_len;
    logic [15:0] pay_left;
    logic [31:0] word_sum;
    logic [7:0]  low_byte;
    logic        have_low;
    result_t     expected_results[$];

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    function automatic logic [15:0] take_digit(input logic [15:0] v, input logic [7:0] b);
        if (stopped)
            return v;
        if (!is_dec(b)) begin
            stopped = 1'b1;
            return v;
        end
        return v * 16'd10 + {12'd0, b[3:0]};
    endfunction

    function automatic void start_payload();
        pay_left = pay_len;
        phase = (pay_len == 16'd0) ? PH_DONE : PH_PAYLOAD;
    endfunction

    function automatic void clear_packet();
        phase = PH_SEQ;
        seq_ok = 1'b0;
        digits = 4'd0;
        stopped = 1'b0;
        hdr_sum = 16'd0;
        pay_len = 16'd0;
        pay_left = 16'd0;
        word_sum = 32'd0;
        low_byte = 8'd0;
        have_low = 1'b0;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic [31:0] s;
        logic        short_pkt;
        logic        ok;
        case (phase)
            PH_SEQ: begin
                seq_ok = (b == ASCII_ZERO + {7'd0, want_seq});
                phase = PH_CKLEN;
            end
            PH_CKLEN: begin
                digits = is_dec(b) ? b[3:0] : 4'd0;
                stopped = 1'b0;
                hdr_sum = 16'd0;
                phase = (digits == 4'd0) ? PH_LENLEN : PH_CKVAL;
            end
            PH_CKVAL: begin
                hdr_sum = take_digit(hdr_sum, b);
                digits = digits - 4'd1;
                if (digits == 4'd0)
                    phase = PH_LENLEN;
            end
            PH_LENLEN: begin
                digits = is_dec(b) ? b[3:0] : 4'd0;
                stopped = 1'b0;
                pay_len = 16'd0;
                if (digits == 4'd0)
                    start_payload();
                else
                    phase = PH_LENVAL;
            end
            PH_LENVAL: begin
                pay_len = take_digit(pay_len, b);
                digits = digits - 4'd1;
                if (digits == 4'd0)
                    start_payload();
            end
            PH_PAYLOAD: begin
                if (have_low) begin
                    word_sum = word_sum + {16'd0, b, low_byte};
                    have_low = 1'b0;
                end else begin
                    low_byte = b;
                    have_low = 1'b1;
                end
                pay_left = pay_left - 16'd1;
                if (pay_left == 16'd0)
                    phase = PH_DONE;
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.ack_seq = ACK_ZERO;
                r.all_done = (good_count >= target_count);
                r.run_end = !last;
                expected_results.push_back(r);
            end
            default: ;
        endcase

        if (last) begin
            s = word_sum + (have_low ? {24'd0, low_byte} : 32'd0);
            while (s[31:16] != 16'd0)
                s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
            short_pkt = (phase != PH_DONE);
            ok = seq_ok && !short_pkt && ((~s[15:0]) == hdr_sum);
            r = '0;
            r.kind = KIND_VERDICT;
            r.accepted = ok;
            r.malformed = short_pkt;
            if (ok) begin
                r.ack_seq = ACK_ZERO + {5'd0, want_seq};
                want_seq = ~want_seq;
                if (good_count != COUNT_MAX)
                    good_count = good_count + 16'd1;
            end else begin
                r.ack_seq = ACK_ZERO + {5'd0, ~want_seq};
            end
            r.all_done = (good_count >= target_count);
            r.run_end = 1'b1;
            expected_results.push_back(r);
            clear_packet();
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction, expected none, actual kind %0d byte 0x%0h",
                     $time, m_kind, m_payload_byte);
        end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, m_kind);
            check_field("payload_byte", want.payload_byte, m_payload_byte);
            check_field("ack_seq", want.ack_seq, m_ack_seq);
            check_field("accepted", want.accepted, m_accepted);
            check_field("malformed", want.malformed, m_malformed);
            check_field("all_done", want.all_done, m_all_done);
            check_field("run_end", want.run_end, m_run_end);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_packet();
            want_seq = 1'b0;
            good_count = 16'd0;
            target_count = 16'd0;
            mismatches = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (cfg_wr_en)
                target_count = cfg_wr_data;
            if (s_valid && s_ready)
                predict_byte(s_pkt_byte, s_pkt_last);
        end
        pending = expected_results.size();
    end

endmodule

### tb/tb_alternating_bit_receiver_top.sv
`timescale 1ns / 100ps
// Testbench top for alternating_bit_receiver_top: clock, reset, packet stimulus,
// random idling on both channels and the final verdict. Depends on abr_pkg and abr_result_checker.
module tb_alternating_bit_receiver_top;
    import abr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 187;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_pkt_byte;
    logic        s_pkt_last;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [7:0]  m_payload_byte;
    logic [5:0]  m_ack_seq;
    logic        m_accepted;
    logic        m_malformed;
    logic        m_all_done;
    logic        m_run_end;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int          mismatches;
    int          pending;
    logic        want_seq;
    bit          gaps_on = 1'b1;
    int          cycle_count = 0;
    int          sent_bytes = 0;
    logic [7:0]  pkt_q[$];

    alternating_bit_receiver_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pkt_byte     (s_pkt_byte),
        .s_pkt_last     (s_pkt_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_ack_seq      (m_ack_seq),
        .m_accepted     (m_accepted),
        .m_malformed    (m_malformed),
        .m_all_done     (m_all_done),
        .m_run_end      (m_run_end),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    abr_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pkt_byte     (s_pkt_byte),
        .s_pkt_last     (s_pkt_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_ack_seq      (m_ack_seq),
        .m_accepted     (m_accepted),
        .m_malformed    (m_malformed),
        .m_all_done     (m_all_done),
        .m_run_end      (m_run_end),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .want_seq       (want_seq)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = gaps_on ? ($urandom_range(99) >= 16) : 1'b1;
        end
    end

    function automatic int digit_count(input int v);
        int d;
        d = 1;
        while (v >= 10) begin
            v = v / 10;
            d++;
        end
        return d;
    endfunction

    task automatic add_number(input int value, input int ndigits);
        int i;
        int div;
        for (i = ndigits - 1; i >= 0; i--) begin
            div = 10 ** i;
            pkt_q.push_back(ASCII_ZERO + 8'((value / div) % 10));
        end
    endtask

    task automatic add_text(input string t);
        int i;
        for (i = 0; i < t.len(); i++)
            pkt_q.push_back(t[i]);
    endtask

    // sequence char, header checksum (optionally wrong or wrapped), length (optionally
    // wrapped), random payload and trailing bytes
    task automatic build_packet(input logic [7:0] seq_char, input bit ck_good, input int len,
                                input int ck_wrap, input int len_wrap, input int trail);
        logic [7:0]  body[$];
        logic [31:0] acc;
        int          i;
        int          ck;
        int          nd;
        int          len_val;
        pkt_q.delete();
        acc = 32'd0;
        for (i = 0; i < len; i++)
            body.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < len; i += 2) begin
            if (i + 1 < len)
                acc = acc + {16'd0, body[i+1], body[i]};
            else
                acc = acc + {24'd0, body[i]};
        end
        while (acc[31:16] != 16'd0)
            acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        ck = 32'hFFFF ^ {16'd0, acc[15:0]};
        if (!ck_good)
            ck = (ck + $urandom_range(1, 65535)) % 65536;
        ck = ck + 65536 * ck_wrap;
        pkt_q.push_back(seq_char);
        nd = digit_count(ck) + (($urandom_range(99) < 20) ? 1 : 0);
        if (nd > 9)
            nd = 9;
        pkt_q.push_back(ASCII_ZERO + 8'(nd));
        add_number(ck, nd);
        len_val = len + 65536 * len_wrap;
        if (len_val == 0 && $urandom_range(1) == 1) begin
            pkt_q.push_back(ASCII_ZERO);
        end else begin
            nd = digit_count(len_val) + (($urandom_range(99) < 20) ? 1 : 0);
            if (nd > 9)
                nd = 9;
            pkt_q.push_back(ASCII_ZERO + 8'(nd));
            add_number(len_val, nd);
        end
        for (i = 0; i < len; i++)
            pkt_q.push_back(body[i]);
        for (i = 0; i < trail; i++)
            pkt_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic random_packet();
        int         pick;
        int         len;
        int         cut;
        int         n;
        int         i;
        logic [7:0] seq_char;
        pick = $urandom_range(99);
        seq_char = ASCII_ZERO + {7'd0, ($urandom_range(99) < 85) ? want_seq : ~want_seq};
        len = ($urandom_range(99) < 90) ? $urandom_range(0, 12) : $urandom_range(13, 60);
        if (pick < 86) begin
            build_packet(seq_char, $urandom_range(99) < 90, len,
                         ($urandom_range(99) < 5) ? $urandom_range(1, 9999) : 0,
                         ($urandom_range(99) < 5) ? $urandom_range(1, 9999) : 0,
                         ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0);
            // truncated packet
            if (pick >= 72 && pkt_q.size() > 1) begin
                cut = $urandom_range(1, pkt_q.size() - 1);
                while (pkt_q.size() > cut)
                    void'(pkt_q.pop_back());
            end
        end else begin
            pkt_q.delete();
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++)
                pkt_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gaps_on && $urandom_range(99) < 16) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pkt_byte = b;
        s_pkt_last = last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_bytes++;
        @(negedge aclk);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_target(input logic [15:0] v);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        logic [15:0] targets[6];
        int          p;
        int          phase_goal;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pkt_byte = 8'd0;
        s_pkt_last = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        write_target(16'd2);

        // good packet, empty payload, checksum 65535
        build_packet(ASCII_ZERO, 1'b1, 0, 0, 0, 0);
        send_packet();
        // wrong sequence, length digits stopped by a non-digit, extreme payload bytes
        pkt_q.delete();
        add_text("0022x");
        pkt_q.push_back(8'hFF);
        pkt_q.push_back(8'h00);
        send_packet();
        // checksum wider than 16 bits, one odd payload byte ending the packet
        pkt_q.delete();
        add_text("1699999911");
        pkt_q.push_back(8'hAA);
        send_packet();
        // packet cut after the sequence byte
        pkt_q.delete();
        add_text("1");
        send_packet();
        // non-digit count bytes, trailing byte after the payload
        pkt_q.delete();
        add_text("1A?9");
        send_packet();
        drain();

        targets[0] = 16'hFFFF;
        targets[1] = 16'd3;
        targets[2] = 16'd0;
        targets[3] = 16'd25;
        targets[4] = 16'($urandom_range(0, 80));
        targets[5] = 16'd150;
        phase_goal = sent_bytes;
        for (p = 0; p < 6; p++) begin
            write_target(targets[p]);
            gaps_on = (p != 2);
            phase_goal = phase_goal + PHASE_BYTES;
            while (sent_bytes < phase_goal) begin
                random_packet();
                send_packet();
            end
            drain();
        end
        gaps_on = 1'b1;

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/abr_pkg.sv
rtl/core/abr_res_fifo.sv
rtl/core/abr_rx_core.sv
rtl/core/alternating_bit_receiver_top.sv
tb/abr_result_checker.sv
tb/tb_alternating_bit_receiver_top.sv
